// ----- hw/rtl/msbmu_pkg.sv -----
// Shared types, constants and helpers for the min-sum message update block.
// No dependencies; every other file in this block imports it.
package msbmu_pkg;

    localparam int NUM_LABELS = 16;
    localparam int LBL_W      = $clog2(NUM_LABELS);
    localparam int COL_W      = 6;
    localparam int ROW_W      = 6;
    localparam int MAX_COLS   = 1 << COL_W;
    localparam int MAX_ROWS   = 1 << ROW_W;
    localparam int PIX_W      = COL_W + ROW_W;
    localparam int PIXELS     = MAX_COLS * MAX_ROWS;
    localparam int NUM_SLOTS  = 4;
    localparam int SLOT_W     = 2;
    localparam int COST_W     = 8;
    localparam int MSG_W      = 24;
    // Wide enough for a data cost plus all four messages, unsaturated.
    localparam int ACC_W      = $clog2((1 << COST_W) + NUM_SLOTS * (1 << MSG_W));
    localparam int GRID_W     = 7;
    localparam int CAP_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [MSG_W-1:0] MSG_SAT = '1;

    // Item kinds
    localparam logic [1:0] KIND_COST   = 2'd0;
    localparam logic [1:0] KIND_SEND   = 2'd1;
    localparam logic [1:0] KIND_DECIDE = 2'd2;

    // Send directions
    localparam logic [1:0] DIR_LEFT  = 2'd0;
    localparam logic [1:0] DIR_RIGHT = 2'd1;
    localparam logic [1:0] DIR_UP    = 2'd2;
    localparam logic [1:0] DIR_DOWN  = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH_CAP  = 2'd2;

    typedef struct packed {
        logic [1:0]        kind;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic [1:0]        direction;
        logic [3:0]        label;
        logic [COST_W-1:0] cost_value;
    } t_item;

    typedef struct packed {
        logic [3:0]       best_label;
        logic [MSG_W-1:0] best_total;
    } t_result;

    // One label of one pixel: data cost and the four incoming messages.
    typedef struct packed {
        logic [COST_W-1:0]                 cost;
        logic [NUM_SLOTS-1:0][MSG_W-1:0]   msg;
    } t_entry;

    typedef t_entry [NUM_LABELS-1:0] t_node;

    // Write request into the node store.
    typedef struct packed {
        logic                              clear;
        logic                              cost_en;
        logic [LBL_W-1:0]                  cost_label;
        logic [COST_W-1:0]                 cost;
        logic                              msg_en;
        logic [SLOT_W-1:0]                 msg_slot;
        logic [NUM_LABELS-1:0][MSG_W-1:0]  msgs;
        logic [PIX_W-1:0]                  addr;
    } t_store_wr;

    function automatic logic [MSG_W-1:0] sat_msg(input logic [ACC_W-1:0] v);
        logic [MSG_W-1:0] res;
        res = (v > ACC_W'(MSG_SAT)) ? MSG_SAT : v[MSG_W-1:0];
        return res;
    endfunction

endpackage

// ----- hw/rtl/msbmu_store.sv -----
// Node store: one row per pixel holding data costs and incoming messages.
// Depends on msbmu_pkg for the row and write request types.
module msbmu_store import msbmu_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rd_en,
    input  logic [PIX_W-1:0] i_rd_addr,
    output t_node            o_rd_node,
    input  t_store_wr        i_wr
);

    t_node mem [PIXELS];
    t_node r_rd_node;

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_node <= mem[i_rd_addr];
        end
        if (i_wr.clear) begin
            mem[i_wr.addr] <= '0;
        end else begin
            // field-level write enables: one label's cost byte, one message slot in every label
            for (int l = 0; l < NUM_LABELS; l++) begin
                if (i_wr.cost_en && (i_wr.cost_label == LBL_W'(l))) begin
                    mem[i_wr.addr][l].cost <= i_wr.cost;
                end
                for (int k = 0; k < NUM_SLOTS; k++) begin
                    if (i_wr.msg_en && (i_wr.msg_slot == SLOT_W'(k))) begin
                        mem[i_wr.addr][l].msg[k] <= i_wr.msgs[l];
                    end
                end
            end
        end
    end

    assign o_rd_node = r_rd_node;

endmodule

// ----- hw/rtl/msbmu_acu.sv -----
// Shared add-compare unit: one wide add and a compare against a reference.
// Depends on msbmu_pkg for the accumulator width.
module msbmu_acu import msbmu_pkg::*; (
    input  logic [ACC_W-1:0] i_a,
    input  logic [ACC_W-1:0] i_b,
    input  logic [ACC_W-1:0] i_ref,
    output logic [ACC_W-1:0] o_sum,
    output logic             o_lt
);

    // Operands stay bounded so the sum never wraps at ACC_W bits.
    assign o_sum = i_a + i_b;
    assign o_lt  = (o_sum < i_ref);

endmodule

// ----- hw/rtl/min_sum_belief_message_update.sv -----
// Min-sum message update top level: sequencer, configuration and result register.
// Depends on msbmu_pkg, msbmu_store and msbmu_acu.
// Behaviour: a cost write takes effect at its accepting edge and leaves busy low; a valid
// send keeps busy high through the partial sums, the add-compare minimum and a store write;
// a decide on the grid keeps busy high and strobes o_done in the cycle after its last step.
// Each step uses the single add-compare unit. Reset: synchronous; then the store is cleared, busy high.
module min_sum_belief_message_update import msbmu_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  t_item                 i_item,
    output logic                  o_done,
    output t_result               o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HSUM,
        S_MIN,
        S_SEND,
        S_DECIDE
    } t_state;

    localparam logic [LBL_W-1:0]  LBL_LAST  = LBL_W'(NUM_LABELS - 1);
    localparam logic [SLOT_W-1:0] HSUM_LAST = SLOT_W'(NUM_SLOTS - 2);
    localparam logic [SLOT_W-1:0] DEC_LAST  = SLOT_W'(NUM_SLOTS - 1);

    // control and datapath registers
    t_state            r_state,     n_state;
    logic [PIX_W-1:0]  r_clr_addr,  n_clr_addr;
    logic [GRID_W-1:0] r_gw,        n_gw;
    logic [GRID_W-1:0] r_gh,        n_gh;
    logic [CAP_W-1:0]  r_cap,       n_cap;
    logic [PIX_W-1:0]  r_tpix,      n_tpix;
    logic [1:0]        r_dir,       n_dir;
    logic [LBL_W-1:0]  r_lbl,       n_lbl;
    logic [LBL_W-1:0]  r_src,       n_src;
    logic [SLOT_W-1:0] r_step,      n_step;
    logic [ACC_W-1:0]  r_acc,       n_acc;
    logic [ACC_W-1:0]  r_best,      n_best;
    logic [LBL_W-1:0]  r_best_lbl,  n_best_lbl;
    logic              r_done,      n_done;
    t_result           r_result,    n_result;

    // per-source partial sums and the outgoing message vector
    logic [ACC_W-1:0]                 r_h [NUM_LABELS];
    logic [NUM_LABELS-1:0][MSG_W-1:0] r_vec;
    logic                             h_we;
    logic                             vec_we;

    // store ports
    logic             rd_en;
    logic [PIX_W-1:0] rd_addr;
    t_node            node;
    t_store_wr        wr;

    // shared unit ports
    logic [ACC_W-1:0] acu_a;
    logic [ACC_W-1:0] acu_b;
    logic [ACC_W-1:0] acu_ref;
    logic [ACC_W-1:0] acu_sum;
    logic             acu_lt;

    // item decode
    logic              accept;
    logic [PIX_W-1:0]  in_pix;
    logic              node_ok;
    logic              edge_ok;
    logic              tgt_ok;
    logic [GRID_W-1:0] tcol;
    logic [GRID_W-1:0] trow;

    // datapath helpers
    logic [LBL_W-1:0]  sel;
    logic [SLOT_W-1:0] hsum_slot;
    logic [LBL_W-1:0]  diff;
    logic [CAP_W-1:0]  pen;
    logic              dec_take;
    logic [ACC_W-1:0]  dec_best;
    logic [LBL_W-1:0]  dec_lbl;

    msbmu_store u_store (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_node (node),
        .i_wr      (wr)
    );

    msbmu_acu u_acu (
        .i_a   (acu_a),
        .i_b   (acu_b),
        .i_ref (acu_ref),
        .o_sum (acu_sum),
        .o_lt  (acu_lt)
    );

    assign busy     = (r_state != S_IDLE);
    assign accept   = start && !busy;
    assign o_done   = r_done;
    assign o_result = r_result;

    // Pixel index is row-major with a power-of-two row pitch.
    assign in_pix  = {i_item.row, i_item.col};
    assign node_ok = (GRID_W'(i_item.col) < r_gw) && (GRID_W'(i_item.row) < r_gh);

    // Neighbor that receives the message; left and up stop at the border.
    always_comb begin
        tcol    = GRID_W'(i_item.col);
        trow    = GRID_W'(i_item.row);
        edge_ok = 1'b1;
        unique case (i_item.direction)
            DIR_LEFT: begin
                edge_ok = (i_item.col != '0);
                tcol    = GRID_W'(i_item.col) - GRID_W'(1);
            end
            DIR_RIGHT: begin
                tcol = GRID_W'(i_item.col) + GRID_W'(1);
            end
            DIR_UP: begin
                edge_ok = (i_item.row != '0);
                trow    = GRID_W'(i_item.row) - GRID_W'(1);
            end
            DIR_DOWN: begin
                trow = GRID_W'(i_item.row) + GRID_W'(1);
            end
            default: begin
                edge_ok = 1'b0;
            end
        endcase
    end

    assign tgt_ok = edge_ok && (tcol < r_gw) && (trow < r_gh)
                 && (tcol < GRID_W'(MAX_COLS)) && (trow < GRID_W'(MAX_ROWS));

    // Skip the slot the message came from: steps 0..2 map to the other three slots.
    assign hsum_slot = r_step + SLOT_W'(r_step >= r_dir);
    assign sel       = (r_state == S_DECIDE) ? r_lbl : r_src;

    // Truncated-linear smoothness cost between target label and source label.
    assign diff = (r_lbl > r_src) ? (r_lbl - r_src) : (r_src - r_lbl);
    assign pen  = (CAP_W'(diff) < r_cap) ? CAP_W'(diff) : r_cap;

    // Operand selection for the shared unit.
    always_comb begin
        acu_a   = '0;
        acu_b   = '0;
        acu_ref = '0;
        case (r_state)
            S_HSUM: begin
                acu_a = (r_step == '0) ? ACC_W'(node[sel].cost) : r_acc;
                acu_b = ACC_W'(node[sel].msg[hsum_slot]);
            end
            S_MIN: begin
                acu_a   = ACC_W'(pen);
                acu_b   = r_h[r_src];
                acu_ref = (r_src == '0) ? ACC_W'(MSG_SAT) : r_best;
            end
            S_DECIDE: begin
                acu_a   = (r_step == '0) ? ACC_W'(node[sel].cost) : r_acc;
                acu_b   = ACC_W'(node[sel].msg[r_step]);
                acu_ref = r_best;
            end
            default: begin
            end
        endcase
    end

    // Decide: first label on ties, compare against the saturated running best.
    assign dec_take = (r_lbl == '0) || acu_lt;
    assign dec_best = dec_take ? ACC_W'(sat_msg(acu_sum)) : r_best;
    assign dec_lbl  = dec_take ? r_lbl : r_best_lbl;

    // Sequencer
    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_gw       = r_gw;
        n_gh       = r_gh;
        n_cap      = r_cap;
        n_tpix     = r_tpix;
        n_dir      = r_dir;
        n_lbl      = r_lbl;
        n_src      = r_src;
        n_step     = r_step;
        n_acc      = r_acc;
        n_best     = r_best;
        n_best_lbl = r_best_lbl;
        n_done     = 1'b0;
        n_result   = r_result;
        h_we       = 1'b0;
        vec_we     = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = in_pix;
        wr         = '0;

        // configuration writes are taken in every state
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_GRID_WIDTH:  n_gw  = i_cfg_data[GRID_W-1:0];
                CFG_GRID_HEIGHT: n_gh  = i_cfg_data[GRID_W-1:0];
                CFG_SMOOTH_CAP:  n_cap = i_cfg_data[CAP_W-1:0];
                default: begin
                end
            endcase
        end

        unique case (r_state)
            S_CLEAR: begin
                // zero one pixel row per cycle
                wr.clear   = 1'b1;
                wr.addr    = r_clr_addr;
                n_clr_addr = r_clr_addr + PIX_W'(1);
                if (r_clr_addr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    unique case (i_item.kind)
                        KIND_COST: begin
                            if (node_ok && (32'(i_item.label) < NUM_LABELS)) begin
                                wr.cost_en    = 1'b1;
                                wr.cost_label = LBL_W'(i_item.label);
                                wr.cost       = i_item.cost_value;
                                wr.addr       = in_pix;
                            end
                        end
                        KIND_SEND: begin
                            if (node_ok && tgt_ok) begin
                                rd_en   = 1'b1;
                                n_tpix  = {trow[ROW_W-1:0], tcol[COL_W-1:0]};
                                n_dir   = i_item.direction;
                                n_src   = '0;
                                n_step  = '0;
                                n_state = S_HSUM;
                            end
                        end
                        KIND_DECIDE: begin
                            if (node_ok) begin
                                rd_en   = 1'b1;
                                n_lbl   = '0;
                                n_step  = '0;
                                n_state = S_DECIDE;
                            end else begin
                                // pixel off the grid: report label 0, total 0
                                n_done   = 1'b1;
                                n_result = '0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_HSUM: begin
                // accumulate data cost plus the three other incoming messages
                n_acc = acu_sum;
                if (r_step == HSUM_LAST) begin
                    h_we   = 1'b1;
                    n_step = '0;
                    n_src  = r_src + LBL_W'(1);
                    if (r_src == LBL_LAST) begin
                        n_src   = '0;
                        n_lbl   = '0;
                        n_state = S_MIN;
                    end
                end else begin
                    n_step = r_step + SLOT_W'(1);
                end
            end
            S_MIN: begin
                // minimum over source labels, capped at saturation
                n_best = acu_lt ? acu_sum : acu_ref;
                if (r_src == LBL_LAST) begin
                    vec_we = 1'b1;
                    n_src  = '0;
                    n_lbl  = r_lbl + LBL_W'(1);
                    if (r_lbl == LBL_LAST) begin
                        n_state = S_SEND;
                    end
                end else begin
                    n_src = r_src + LBL_W'(1);
                end
            end
            S_SEND: begin
                // replace the neighbor's incoming message from this side
                wr.msg_en   = 1'b1;
                wr.msg_slot = r_dir ^ SLOT_W'(1);
                wr.msgs     = r_vec;
                wr.addr     = r_tpix;
                n_state     = S_IDLE;
            end
            S_DECIDE: begin
                n_acc = acu_sum;
                if (r_step == DEC_LAST) begin
                    n_best     = dec_best;
                    n_best_lbl = dec_lbl;
                    n_step     = '0;
                    n_lbl      = r_lbl + LBL_W'(1);
                    if (r_lbl == LBL_LAST) begin
                        n_done              = 1'b1;
                        n_result.best_label = 4'(dec_lbl);
                        n_result.best_total = dec_best[MSG_W-1:0];
                        n_state             = S_IDLE;
                    end
                end else begin
                    n_step = r_step + SLOT_W'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_gw       <= GRID_W'(64);
            r_gh       <= GRID_W'(64);
            r_cap      <= CAP_W'(10);
            r_lbl      <= '0;
            r_src      <= '0;
            r_step     <= '0;
            r_done     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_gw       <= n_gw;
            r_gh       <= n_gh;
            r_cap      <= n_cap;
            r_lbl      <= n_lbl;
            r_src      <= n_src;
            r_step     <= n_step;
            r_done     <= n_done;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_tpix     <= n_tpix;
        r_dir      <= n_dir;
        r_acc      <= n_acc;
        r_best     <= n_best;
        r_best_lbl <= n_best_lbl;
        r_result   <= n_result;
        if (h_we) begin
            r_h[r_src] <= acu_sum;
        end
        if (vec_we) begin
            r_vec[r_lbl] <= n_best[MSG_W-1:0];
        end
    end

endmodule
